[rtl/core/hrc_pkg.sv]
// Shared types and constants for the Hough rectangle corner block.
package hrc_pkg;

  // Fixed field widths
  localparam int unsigned ANGLE_W       = 12;
  localparam int unsigned RHO_W         = 17;
  localparam int unsigned RHO_FRAC_BITS = 4;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned HALF_W        = CFG_W - 1;
  // Folded angle width, covers a quarter turn at the finest angle resolution
  localparam int unsigned REM_W         = 15;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Sine series constants (Q30)
  localparam longint unsigned PI_Q30    = 64'd3373259426;
  localparam longint unsigned ONE_Q30   = 64'd1 << 30;
  localparam int unsigned     SIN_TERMS = 7;
  localparam longint unsigned SIN_DIV [SIN_TERMS] = '{
    64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
  };

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // Classified word passed from front to back
  typedef struct packed {
    quad_e            quad;
    logic [REM_W-1:0] rem;
    logic             neg;
    logic [RHO_W-1:0] rho_one;
    logic [RHO_W-1:0] rho_two;
  } item_t;

endpackage

[rtl/core/hrc_front.sv]
// Front end: takes a word, reduces the angle and classifies its quadrant.
module hrc_front #(
  parameter int unsigned ANGLE_FRAC_BITS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [hrc_pkg::ANGLE_W-1:0]  angle_i,
  input  logic signed [hrc_pkg::RHO_W-1:0]    rho_one_i,
  input  logic signed [hrc_pkg::RHO_W-1:0]    rho_two_i,
  output logic                                busy_o,
  output logic                                valid_o,
  output hrc_pkg::item_t                      item_o,
  input  logic                                q_ready_i
);

  localparam int unsigned FULL      = 360 << ANGLE_FRAC_BITS;
  localparam int unsigned QUARTER   = 90 << ANGLE_FRAC_BITS;
  localparam int unsigned ANG_SPAN  = 1 << (hrc_pkg::ANGLE_W - 1);
  // Multiple of a full turn that lifts any input angle above zero
  localparam int unsigned OFFS      = FULL * ((ANG_SPAN + FULL - 1) / FULL);
  localparam int unsigned RED_STEPS = 4;
  localparam int unsigned RED_W     = $clog2(FULL) + RED_STEPS;

  hrc_pkg::item_t item_d, item_q;
  logic           valid_q, valid_d;
  logic           load;

  always_comb begin
    logic [RED_W-1:0] m;
    logic             q_hi;
    logic             q_lo;
    m = RED_W'(angle_i) + RED_W'(OFFS);
    // Restoring reduction modulo a full turn
    for (int j = RED_STEPS - 1; j >= 0; j--) begin
      if (m >= RED_W'(FULL << j)) begin
        m = m - RED_W'(FULL << j);
      end
    end
    q_hi = (m >= RED_W'(2 * QUARTER));
    if (q_hi) begin
      m = m - RED_W'(2 * QUARTER);
    end
    q_lo = (m >= RED_W'(QUARTER));
    if (q_lo) begin
      m = m - RED_W'(QUARTER);
    end
    item_d.quad    = hrc_pkg::quad_e'({q_hi, q_lo});
    item_d.rem     = hrc_pkg::REM_W'(m);
    item_d.neg     = angle_i[hrc_pkg::ANGLE_W-1];
    item_d.rho_one = rho_one_i;
    item_d.rho_two = rho_two_i;
  end

  assign busy_o  = valid_q && !q_ready_i;
  assign load    = valid_i && !busy_o;
  assign valid_d = load || (valid_q && !q_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/core/hrc_queue.sv]
// Small FIFO between the front end and the arithmetic back end.
module hrc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hrc_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output hrc_pkg::item_t item_o
);

  localparam int unsigned DEPTH = hrc_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hrc_pkg::item_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign push    = push_i && ready_o;
  assign pop     = pop_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("queue fill count did not follow a lone push");

endmodule

[rtl/core/hrc_back.sv]
// Back end: sine/cosine ROM, products, line intersections, image mapping.
module hrc_back #(
  parameter int unsigned ANGLE_FRAC_BITS = 4,
  parameter int unsigned TRIG_FRAC_BITS  = 14,
  parameter int unsigned COORD_WIDTH     = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  hrc_pkg::item_t                     item_i,
  output logic                               pop_o,
  input  logic [hrc_pkg::HALF_W-1:0]         half_width_i,
  input  logic [hrc_pkg::HALF_W-1:0]         half_height_i,
  output logic                               strobe_o,
  output logic signed [COORD_WIDTH-1:0]      corner_x_o [4],
  output logic signed [COORD_WIDTH-1:0]      corner_y_o [4]
);

  localparam int unsigned QUARTER   = 90 << ANGLE_FRAC_BITS;
  localparam int unsigned ROM_DEPTH = QUARTER + 1;
  localparam int unsigned AW        = $clog2(ROM_DEPTH);
  localparam int unsigned TV_W      = TRIG_FRAC_BITS + 2;
  localparam int unsigned TS_W      = TV_W + 1;
  localparam int unsigned PW        = hrc_pkg::RHO_W + TS_W;
  localparam int unsigned SW        = PW + 1;
  localparam int unsigned SH        = TRIG_FRAC_BITS + hrc_pkg::RHO_FRAC_BITS;
  localparam int unsigned TR_W      = SW - SH;
  localparam int unsigned SAT_W     = (TR_W + 2 > COORD_WIDTH + 1) ? TR_W + 2 : COORD_WIDTH + 1;
  localparam int unsigned RND_SH    = 30 - TRIG_FRAC_BITS;
  localparam longint unsigned ANGLE_SCALE = 64'd180 << ANGLE_FRAC_BITS;
  localparam longint unsigned RND         = 64'd1 << (RND_SH - 1);
  localparam longint unsigned TRUNC_BIAS  = (64'd1 << SH) - 64'd1;
  localparam logic signed [SAT_W-1:0] SAT_HI =
    SAT_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

  typedef logic [TV_W-1:0] rom_t [ROM_DEPTH];

  // First-quadrant sine, Q30 series rounded to TRIG_FRAC_BITS
  function automatic rom_t build_rom();
    rom_t            rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned s;
    for (int t = 0; t < ROM_DEPTH; t++) begin
      x  = (longint'(t) * hrc_pkg::PI_Q30) / ANGLE_SCALE;
      x2 = (x * x) >> 30;
      r  = hrc_pkg::ONE_Q30;
      for (int k = 0; k < hrc_pkg::SIN_TERMS; k++) begin
        r = hrc_pkg::ONE_Q30 - (((x2 * r) >> 30) / hrc_pkg::SIN_DIV[k]);
      end
      s      = (x * r) >> 30;
      rom[t] = TV_W'((s + RND) >> RND_SH);
    end
    return rom;
  endfunction

  localparam rom_t SIN_ROM = build_rom();

  function automatic logic signed [TR_W-1:0] trunc_zero(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] b;
    b = v[SW-1] ? v + SW'(TRUNC_BIAS) : v;
    return TR_W'(b >>> SH);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end
    if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return c[COORD_WIDTH-1:0];
  endfunction

  // Stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // Stage 1: ROM read
  logic [TV_W-1:0]                 sq_q, cq_q;
  hrc_pkg::quad_e                  quad1_q;
  logic                            neg1_q, neg2_q;
  logic signed [hrc_pkg::RHO_W-1:0] r1_1_q, r2_1_q;
  logic [AW-1:0]                   sin_addr, cos_addr;

  assign pop_o    = valid_i;
  assign sin_addr = item_i.rem[AW-1:0];
  assign cos_addr = AW'(QUARTER) - sin_addr;

  // Stage 2: quadrant signs and products
  logic signed [TS_W-1:0] c_s, s_s, sq_s, cq_s;
  logic signed [PW-1:0]   pc_q, ps_q, qc_q, qs_q;

  assign sq_s = signed'({1'b0, sq_q});
  assign cq_s = signed'({1'b0, cq_q});

  always_comb begin
    case (quad1_q)
      hrc_pkg::QUAD_0: begin c_s = -cq_s; s_s = sq_s;  end
      hrc_pkg::QUAD_1: begin c_s = sq_s;  s_s = cq_s;  end
      hrc_pkg::QUAD_2: begin c_s = cq_s;  s_s = -sq_s; end
      hrc_pkg::QUAD_3: begin c_s = -sq_s; s_s = -cq_s; end
      default:         begin c_s = '0;    s_s = '0;    end
    endcase
  end

  // Stage 3: line intersections
  logic signed [SW-1:0] xa_q, xb_q, ya_q, yb_q;
  logic signed [SW-1:0] pc_e, ps_e, qc_e, qs_e;

  assign pc_e = SW'(pc_q);
  assign ps_e = SW'(ps_q);
  assign qc_e = SW'(qc_q);
  assign qs_e = SW'(qs_q);

  // Stage 4: truncation toward zero
  logic signed [TR_W-1:0] txa_q, txb_q, tya_q, tyb_q;

  // Stage 5: image mapping and saturation
  logic signed [SAT_W-1:0] hw_e, hh_e, txa_e, txb_e, tya_e, tyb_e;
  logic signed [COORD_WIDTH-1:0] cx_q [4];
  logic signed [COORD_WIDTH-1:0] cy_q [4];

  assign hw_e  = signed'(SAT_W'(half_width_i));
  assign hh_e  = signed'(SAT_W'(half_height_i));
  assign txa_e = SAT_W'(txa_q);
  assign txb_e = SAT_W'(txb_q);
  assign tya_e = SAT_W'(tya_q);
  assign tyb_e = SAT_W'(tyb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      sq_q    <= SIN_ROM[sin_addr];
      cq_q    <= SIN_ROM[cos_addr];
      quad1_q <= item_i.quad;
      neg1_q  <= item_i.neg;
      r1_1_q  <= signed'(item_i.rho_one);
      r2_1_q  <= signed'(item_i.rho_two);
    end
    if (v1_q) begin
      pc_q   <= PW'(r1_1_q) * PW'(c_s);
      ps_q   <= PW'(r1_1_q) * PW'(s_s);
      qc_q   <= PW'(r2_1_q) * PW'(c_s);
      qs_q   <= PW'(r2_1_q) * PW'(s_s);
      neg2_q <= neg1_q;
    end
    if (v2_q) begin
      // neg: second pair at theta+90, so the sine term adds on x
      xa_q   <= neg2_q ? pc_e + qs_e : pc_e - qs_e;
      xb_q   <= neg2_q ? pc_e - qs_e : pc_e + qs_e;
      ya_q   <= neg2_q ? ps_e - qc_e : ps_e + qc_e;
      yb_q   <= neg2_q ? ps_e + qc_e : ps_e - qc_e;
    end
    if (v3_q) begin
      txa_q <= trunc_zero(xa_q);
      txb_q <= trunc_zero(xb_q);
      tya_q <= trunc_zero(ya_q);
      tyb_q <= trunc_zero(yb_q);
    end
    if (v4_q) begin
      // Negated rho pair mirrors the corner through the center
      cx_q[0] <= sat(hw_e + txa_e);
      cy_q[0] <= sat(hh_e - tya_e);
      cx_q[1] <= sat(hw_e + txb_e);
      cy_q[1] <= sat(hh_e - tyb_e);
      cx_q[2] <= sat(hw_e - txb_e);
      cy_q[2] <= sat(hh_e + tyb_e);
      cx_q[3] <= sat(hw_e - txa_e);
      cy_q[3] <= sat(hh_e + tya_e);
    end
  end

  assign strobe_o   = v5_q;
  assign corner_x_o = cx_q;
  assign corner_y_o = cy_q;

endmodule

[rtl/core/hough_rectangle_to_corners_top.sv]
// Top level of the Hough rectangle to corners block.
//
// Takes one rectangle word (angle theta, half-extents rho1 and rho2) per
// cycle on start/busy and returns its four corners in image coordinates,
// marked by a one-cycle strobe_o. The receiver cannot stall, so words leave
// at the rate they enter: one per clock, sustained. A word is registered in
// the front end (angle reduction and quadrant split), then in the two-entry
// queue, then in each back-end stage: sine/cosine ROM read, four
// rho-by-trig multiplies, intersection sums, truncation toward zero, and
// offset plus 16-bit saturation. busy stays low in normal use since the
// back end drains the queue every cycle. The sine ROM holds one quarter
// turn (90 << ANGLE_FRAC_BITS + 1 entries, TRIG_FRAC_BITS + 2 bits wide)
// and is read at two addresses per word.
// image_width and image_height are written through the cfg port and
// should only change while no word is in flight.
module hough_rectangle_to_corners_top #(
  parameter int unsigned ANGLE_FRAC_BITS = 4,
  parameter int unsigned TRIG_FRAC_BITS  = 14,
  parameter int unsigned COORD_WIDTH     = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Command channel
  input  logic                               start,
  output logic                               busy,
  input  logic signed [hrc_pkg::ANGLE_W-1:0] angle_deg_i,
  input  logic signed [hrc_pkg::RHO_W-1:0]   half_extent_one_i,
  input  logic signed [hrc_pkg::RHO_W-1:0]   half_extent_two_i,
  // Register write port
  input  logic                               cfg_we_i,
  input  logic [0:0]                         cfg_idx_i,
  input  logic [hrc_pkg::CFG_W-1:0]          cfg_wdata_i,
  // Result channel
  output logic                               strobe_o,
  output logic signed [COORD_WIDTH-1:0]      corner0_x_o,
  output logic signed [COORD_WIDTH-1:0]      corner0_y_o,
  output logic signed [COORD_WIDTH-1:0]      corner1_x_o,
  output logic signed [COORD_WIDTH-1:0]      corner1_y_o,
  output logic signed [COORD_WIDTH-1:0]      corner2_x_o,
  output logic signed [COORD_WIDTH-1:0]      corner2_y_o,
  output logic signed [COORD_WIDTH-1:0]      corner3_x_o,
  output logic signed [COORD_WIDTH-1:0]      corner3_y_o
);

  localparam logic [hrc_pkg::CFG_W-1:0] WIDTH_RST  = hrc_pkg::CFG_W'(640);
  localparam logic [hrc_pkg::CFG_W-1:0] HEIGHT_RST = hrc_pkg::CFG_W'(480);

  // Config registers
  logic [hrc_pkg::CFG_W-1:0] image_width_q, image_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WIDTH_RST;
      image_height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hrc_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i;
        hrc_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front end -> queue
  logic           fr_valid, q_ready;
  hrc_pkg::item_t fr_item;

  hrc_front #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start),
    .angle_i   (angle_deg_i),
    .rho_one_i (half_extent_one_i),
    .rho_two_i (half_extent_two_i),
    .busy_o    (busy),
    .valid_o   (fr_valid),
    .item_o    (fr_item),
    .q_ready_i (q_ready)
  );

  // Queue -> back end
  logic           q_valid, q_pop;
  hrc_pkg::item_t q_item;

  hrc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .item_i  (fr_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  logic signed [COORD_WIDTH-1:0] cx [4];
  logic signed [COORD_WIDTH-1:0] cy [4];

  // Image center offsets, floor halves
  hrc_back #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .TRIG_FRAC_BITS  (TRIG_FRAC_BITS),
    .COORD_WIDTH     (COORD_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .item_i        (q_item),
    .pop_o         (q_pop),
    .half_width_i  (image_width_q[hrc_pkg::CFG_W-1:1]),
    .half_height_i (image_height_q[hrc_pkg::CFG_W-1:1]),
    .strobe_o      (strobe_o),
    .corner_x_o    (cx),
    .corner_y_o    (cy)
  );

  assign corner0_x_o = cx[0];
  assign corner0_y_o = cy[0];
  assign corner1_x_o = cx[1];
  assign corner1_y_o = cy[1];
  assign corner2_x_o = cx[2];
  assign corner2_y_o = cy[2];
  assign corner3_x_o = cx[3];
  assign corner3_y_o = cy[3];

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##7 strobe_o)
    else $error("accepted word did not produce corners after seven cycles");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start && !busy, 7))
    else $error("corner strobe without an accepted word");

endmodule

[verif/hrc_corner_checker.sv]
// Checker for the Hough rectangle corner block: predicts corner sets and compares them.
module hrc_corner_checker #(
  parameter int unsigned ANGLE_FRAC_BITS = 4,
  parameter int unsigned TRIG_FRAC_BITS  = 14,
  parameter int unsigned COORD_WIDTH     = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  logic signed [hrc_pkg::ANGLE_W-1:0] angle_deg_i,
  input  logic signed [hrc_pkg::RHO_W-1:0]   half_extent_one_i,
  input  logic signed [hrc_pkg::RHO_W-1:0]   half_extent_two_i,
  input  logic                               cfg_we_i,
  input  logic [0:0]                         cfg_idx_i,
  input  logic [hrc_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               strobe_i,
  input  logic [COORD_WIDTH-1:0]             corner0_x_i,
  input  logic [COORD_WIDTH-1:0]             corner0_y_i,
  input  logic [COORD_WIDTH-1:0]             corner1_x_i,
  input  logic [COORD_WIDTH-1:0]             corner1_y_i,
  input  logic [COORD_WIDTH-1:0]             corner2_x_i,
  input  logic [COORD_WIDTH-1:0]             corner2_y_i,
  input  logic [COORD_WIDTH-1:0]             corner3_x_i,
  input  logic [COORD_WIDTH-1:0]             corner3_y_i,
  output int                                 errors_o,
  output int                                 pending_o,
  output int                                 checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned Q30_ONE    = 64'd1 << 30;
  localparam longint unsigned Q30_PI     = 64'd3373259426;
  localparam int unsigned     TRIG_SHIFT = 30 - TRIG_FRAC_BITS;
  localparam int unsigned     PROD_FRAC  = TRIG_FRAC_BITS + hrc_pkg::RHO_FRAC_BITS;
  localparam longint unsigned SERIES_DIV [7] = '{
    64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
  };

  // corner set packed low to high: c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y
  typedef logic [7:0][COORD_WIDTH-1:0] corners_t;

  string coord_name [8] = '{
    "corner0_x", "corner0_y", "corner1_x", "corner1_y",
    "corner2_x", "corner2_y", "corner3_x", "corner3_y"
  };

  logic [hrc_pkg::CFG_W-1:0] width_q;
  logic [hrc_pkg::CFG_W-1:0] height_q;
  corners_t         corners_due [$];
  corners_t         got;
  corners_t         want;
  int               err_cnt;
  int               pending_cnt;
  int               checked_cnt;

  assign errors_o  = err_cnt;
  assign pending_o = pending_cnt;
  assign checked_o = checked_cnt;

  // sine of a first-quadrant angle (units of 2^-ANGLE_FRAC_BITS degree), Q30,
  // odd Taylor series evaluated in nested form
  function automatic longint unsigned quarter_sine_q30(longint unsigned t);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    int              n;
    x  = (t * Q30_PI) / (64'd180 << ANGLE_FRAC_BITS);
    x2 = (x * x) >> 30;
    r  = Q30_ONE;
    for (n = 0; n < 7; n++) begin
      r = Q30_ONE - (((x2 * r) >> 30) / SERIES_DIV[n]);
    end
    return (x * r) >> 30;
  endfunction

  // Q30 down to trig precision, round half up
  function automatic longint trig_round(longint unsigned q30);
    return longint'((q30 + (64'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT);
  endfunction

  function automatic longint trunc_frac(longint v);
    longint unsigned mag;
    if (v < 0) begin
      mag = longint'(-v);
      return -longint'(mag >> PROD_FRAC);
    end
    return longint'(longint'(v) >>> PROD_FRAC);
  endfunction

  function automatic logic [COORD_WIDTH-1:0] clamp_coord(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[COORD_WIDTH-1:0];
  endfunction

  function automatic corners_t predict_corners(
    logic signed [hrc_pkg::ANGLE_W-1:0] angle,
    logic signed [hrc_pkg::RHO_W-1:0]   rho_one,
    logic signed [hrc_pkg::RHO_W-1:0]   rho_two);
    corners_t       res;
    longint         a, full, quarter, m, rem;
    longint         sq, cq, sn, cs, c, s, g;
    longint         xb, yb, xn, yn;
    longint         p [2];
    longint         q [2];
    hrc_pkg::quad_e quad;
    int             i, j, k;
    a       = angle;
    full    = longint'(360) << ANGLE_FRAC_BITS;
    quarter = longint'(90) << ANGLE_FRAC_BITS;
    m       = a % full;
    if (m < 0) m = m + full;
    quad = hrc_pkg::quad_e'(m / quarter);
    rem  = m % quarter;
    sq   = trig_round(quarter_sine_q30(longint'(rem)));
    cq   = trig_round(quarter_sine_q30(longint'(quarter - rem)));
    case (quad)
      hrc_pkg::QUAD_0: begin sn = sq;  cs = cq;  end
      hrc_pkg::QUAD_1: begin sn = cq;  cs = -sq; end
      hrc_pkg::QUAD_2: begin sn = -sq; cs = -cq; end
      default: begin sn = -cq; cs = sq; end
    endcase
    c = -cs;
    s = sn;
    // zero angle takes the theta-90 branch
    g = (a < 0) ? 1 : -1;
    p[0] = rho_one;
    p[1] = -longint'(rho_one);
    q[0] = rho_two;
    q[1] = -longint'(rho_two);
    xb = longint'(width_q >> 1);
    yb = longint'(height_q >> 1);
    for (i = 0; i < 2; i++) begin
      for (j = 0; j < 2; j++) begin
        k  = i * 2 + j;
        xn = p[i] * c + g * s * q[j];
        yn = p[i] * s - g * c * q[j];
        res[2*k]   = clamp_coord(trunc_frac(xn) + xb);
        res[2*k+1] = clamp_coord(yb - trunc_frac(yn));
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= hrc_pkg::CFG_W'(640);
      height_q    <= hrc_pkg::CFG_W'(480);
      corners_due.delete();
      err_cnt     = 0;
      pending_cnt = 0;
      checked_cnt = 0;
    end else begin
      // results first: a word accepted at this edge cannot already be out
      if (strobe_i) begin
        got = {corner3_y_i, corner3_x_i, corner2_y_i, corner2_x_i,
               corner1_y_i, corner1_x_i, corner0_y_i, corner0_x_i};
        if (corners_due.size() == 0) begin
          $error("corner set with no rectangle outstanding");
          err_cnt++;
        end else begin
          want = corners_due.pop_front();
          checked_cnt++;
          for (int n = 0; n < 8; n++) begin
            if (got[n] !== want[n]) begin
              $error("%s: expected %0d, got %0d", coord_name[n],
                     $signed(want[n]), $signed(got[n]));
              err_cnt++;
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        corners_due.insert(corners_due.size(),
                           predict_corners(angle_deg_i, half_extent_one_i,
                                           half_extent_two_i));
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == hrc_pkg::REG_IMAGE_WIDTH) width_q <= cfg_wdata_i;
        else height_q <= cfg_wdata_i;
      end
      pending_cnt = corners_due.size();
    end
  end

endmodule

[verif/tb_hough_rectangle_to_corners_top.sv]
// Testbench top for the Hough rectangle corner block: stimulus, register phases and verdict.
module tb_hough_rectangle_to_corners_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ANGLE_FRAC   = 4;
  localparam int unsigned TRIG_FRAC    = 14;
  localparam int unsigned COORD_W      = 16;
  localparam int          PIPE_LATENCY = 7;    // start accept to strobe
  localparam int          STALL_LIMIT  = 2000; // cycles with no traffic at all
  localparam int          PHASE_WORDS  = 300;  // random words per register setting

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // command side, all driven from time zero
  logic                               start = 1'b0;
  logic                               busy;
  logic signed [hrc_pkg::ANGLE_W-1:0] angle_deg_i = '0;
  logic signed [hrc_pkg::RHO_W-1:0]   half_extent_one_i = '0;
  logic signed [hrc_pkg::RHO_W-1:0]   half_extent_two_i = '0;

  // register write port
  logic                               cfg_we_i = 1'b0;
  logic [0:0]                         cfg_idx_i = '0;
  logic [hrc_pkg::CFG_W-1:0]          cfg_wdata_i = '0;

  // result side
  logic                      strobe_o;
  logic signed [COORD_W-1:0] corner0_x_o, corner0_y_o, corner1_x_o, corner1_y_o;
  logic signed [COORD_W-1:0] corner2_x_o, corner2_y_o, corner3_x_o, corner3_y_o;

  // checker status
  int err_total;
  int words_pending;
  int sets_checked;

  // run bookkeeping
  int words_sent;
  int size_phases;
  int stall_cycles;
  int run_left;
  bit calm_run;

  hough_rectangle_to_corners_top #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC),
    .TRIG_FRAC_BITS  (TRIG_FRAC),
    .COORD_WIDTH     (COORD_W)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .angle_deg_i       (angle_deg_i),
    .half_extent_one_i (half_extent_one_i),
    .half_extent_two_i (half_extent_two_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .strobe_o          (strobe_o),
    .corner0_x_o       (corner0_x_o),
    .corner0_y_o       (corner0_y_o),
    .corner1_x_o       (corner1_x_o),
    .corner1_y_o       (corner1_y_o),
    .corner2_x_o       (corner2_x_o),
    .corner2_y_o       (corner2_y_o),
    .corner3_x_o       (corner3_x_o),
    .corner3_y_o       (corner3_y_o)
  );

  // the checker sits beside the block and only listens
  hrc_corner_checker #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC),
    .TRIG_FRAC_BITS  (TRIG_FRAC),
    .COORD_WIDTH     (COORD_W)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .angle_deg_i       (angle_deg_i),
    .half_extent_one_i (half_extent_one_i),
    .half_extent_two_i (half_extent_two_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .strobe_i          (strobe_o),
    .corner0_x_i       (corner0_x_o),
    .corner0_y_i       (corner0_y_o),
    .corner1_x_i       (corner1_x_o),
    .corner1_y_i       (corner1_y_o),
    .corner2_x_i       (corner2_x_o),
    .corner2_y_i       (corner2_y_o),
    .corner3_x_i       (corner3_x_o),
    .corner3_y_i       (corner3_y_o),
    .errors_o          (err_total),
    .pending_o         (words_pending),
    .checked_o         (sets_checked)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: any accepted word, strobe or register write counts as progress.
  // A hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no traffic for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // Idle cycles before the next word. Each run is picked at random as either
  // a back-to-back stretch or a stretch of random gaps, so gaps land on every pipe stage.
  task automatic pick_gap(output int gap);
    if (run_left == 0) begin
      run_left = $urandom_range(10, 60);
      calm_run = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    gap = calm_run ? 0 : $urandom_range(0, 3);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with start still high, so a zero gap keeps it high without a glitch.
  task automatic send_word(input int ang, input int rho_one, input int rho_two);
    int gap;
    pick_gap(gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start             <= 1'b1;
    angle_deg_i       <= ang[hrc_pkg::ANGLE_W-1:0];
    half_extent_one_i <= rho_one[hrc_pkg::RHO_W-1:0];
    half_extent_two_i <= rho_two[hrc_pkg::RHO_W-1:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Mostly realistic angles and pixel-scale extents, with a share of raw
  // full-width fields and corner values so every input bit toggles.
  task automatic random_word();
    int ang;
    int rho [2];
    case ($urandom_range(0, 9))
      7, 9:    ang = int'($urandom_range(0, 4095)) - 2048;
      8: begin
        case ($urandom_range(0, 6))
          0: ang = 0;
          1: ang = 1440;
          2: ang = -1440;
          3: ang = 720;
          4: ang = -720;
          5: ang = 1;
          default: ang = -1;
        endcase
      end
      default: ang = int'($urandom_range(0, 2880)) - 1440;
    endcase
    for (int n = 0; n < 2; n++) begin
      case ($urandom_range(0, 9))
        6, 7: rho[n] = int'($urandom_range(0, 131071)) - 65536;
        8: begin
          case ($urandom_range(0, 4))
            0: rho[n] = 65535;
            1: rho[n] = -65536;
            2: rho[n] = 0;
            3: rho[n] = 1;
            default: rho[n] = -1;
          endcase
        end
        default: rho[n] = int'($urandom_range(0, 16384)) - 8192;
      endcase
    end
    send_word(ang, rho[0], rho[1]);
  endtask

  // Wait until every predicted corner set has come back, then let the pipe
  // settle for its latency before touching registers or ending the run.
  task automatic drain();
    start <= 1'b0;
    while (words_pending != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY + 1) @(negedge clk_i);
  endtask

  // Both registers in back-to-back cycles; write enable stays high between.
  task automatic set_image_size(input int w, input int h);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= hrc_pkg::REG_IMAGE_WIDTH;
    cfg_wdata_i <= w[hrc_pkg::CFG_W-1:0];
    @(negedge clk_i);
    cfg_idx_i   <= hrc_pkg::REG_IMAGE_HEIGHT;
    cfg_wdata_i <= h[hrc_pkg::CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    size_phases++;
    @(negedge clk_i);
  endtask

  initial begin
    words_sent  = 0;
    size_phases = 1;
    run_left    = 0;
    calm_run    = 1'b0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words at the reset image size (640 x 480).
    send_word(0, 160, 320);            // zero angle: second pair at theta-90
    send_word(0, -160, -320);
    send_word(0, 0, 0);
    send_word(0, 65535, 65535);
    send_word(1, 65535, -65536);       // smallest positive angle, extreme extents
    send_word(-1, -65536, 65535);      // smallest negative angle
    send_word(1440, 800, 400);         // exactly +90
    send_word(-1440, 800, 400);        // exactly -90
    send_word(720, 1600, 800);
    send_word(-720, 1600, 800);
    send_word(1439, 0, 0);
    send_word(-1439, 1, -1);
    send_word(1441, 480, 240);         // just past +-90
    send_word(-1441, 480, 240);
    send_word(1800, 1000, -500);
    send_word(-1800, -1000, 500);
    send_word(2047, 65535, 65535);     // field extremes, beyond +-90
    send_word(-2048, -65536, -65536);
    send_word(-2048, 0, 0);
    send_word(360, 16, 16);
    send_word(1080, 65535, 0);
    send_word(-360, 0, 65535);

    // Random words under a sequence of image sizes, extremes included:
    // minimum, nominal maximum, zero and all-ones register values.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_image_size(1, 1);
        1: set_image_size(4096, 4096);
        2: set_image_size(0, 8191);
        3: set_image_size(8191, 0);
        4: set_image_size($urandom_range(1, 4096), $urandom_range(1, 4096));
        default: set_image_size(640, 480);
      endcase
      repeat (PHASE_WORDS) random_word();
    end

    drain();

    $display("Sent %0d rectangles (directed and random) over %0d image sizes,",
             words_sent, size_phases);
    $display("with random and back-to-back spacing; %0d corner sets compared.",
             sets_checked);
    if (err_total == 0 && words_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[hough_rectangle_to_corners_top.f]
rtl/core/hrc_pkg.sv
rtl/core/hrc_front.sv
rtl/core/hrc_queue.sv
rtl/core/hrc_back.sv
rtl/core/hough_rectangle_to_corners_top.sv
verif/hrc_corner_checker.sv
verif/tb_hough_rectangle_to_corners_top.sv
